// ===== sv/ttf_pkg.sv =====
package ttf_pkg;

  localparam int POS_W   = 32;
  localparam int TEX_W   = 20;
  localparam int EDGE_W  = 33;
  localparam int DELTA_W = 21;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 66;
  localparam int PAIR_W  = 64;
  localparam int CM_W    = 63;
  localparam int DIVX_W  = 80;
  localparam int DIVD_W  = 43;
  localparam int QUO_W   = 32;
  localparam int STAT_W  = 3;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [QUO_W-1:0] ONE_Q30 = 32'h4000_0000;

  localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO_DET   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO_AREA  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_INCOMPLETE = 3'd4;

  typedef struct packed {
    logic                        incomplete;
    logic [2:0][EDGE_W-1:0]      e1;
    logic [2:0][EDGE_W-1:0]      e2;
    logic [DELTA_W-1:0]          du1;
    logic [DELTA_W-1:0]          dv1;
    logic [DELTA_W-1:0]          du2;
    logic [DELTA_W-1:0]          dv2;
  } job_t;

endpackage

// ===== sv/ttf_if.sv =====
interface ttf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ttf_pkg::POS_W-1:0]  pos_x;
  logic signed [ttf_pkg::POS_W-1:0]  pos_y;
  logic signed [ttf_pkg::POS_W-1:0]  pos_z;
  logic signed [ttf_pkg::TEX_W-1:0]  tex_u;
  logic signed [ttf_pkg::TEX_W-1:0]  tex_v;
  logic                              end_of_mesh;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, end_of_mesh, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, end_of_mesh, output ready);
endinterface

interface ttf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ttf_pkg::POS_W-1:0]  tangent_x;
  logic signed [ttf_pkg::POS_W-1:0]  tangent_y;
  logic signed [ttf_pkg::POS_W-1:0]  tangent_z;
  logic signed [ttf_pkg::POS_W-1:0]  bitangent_x;
  logic signed [ttf_pkg::POS_W-1:0]  bitangent_y;
  logic signed [ttf_pkg::POS_W-1:0]  bitangent_z;
  logic signed [ttf_pkg::POS_W-1:0]  normal_x;
  logic signed [ttf_pkg::POS_W-1:0]  normal_y;
  logic signed [ttf_pkg::POS_W-1:0]  normal_z;
  logic [ttf_pkg::STAT_W-1:0]        frame_status;

  modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                  bitangent_z, normal_x, normal_y, normal_z, frame_status, input ready);
  modport sink (input valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                bitangent_z, normal_x, normal_y, normal_z, frame_status, output ready);
endinterface

// ===== sv/ttf_front.sv =====
module ttf_front (
  input  logic          clk,
  input  logic          rst_n,
  ttf_in_if.sink        in_vtx,
  input  logic          q_full,
  output logic          q_push,
  output ttf_pkg::job_t q_job
);

  logic signed [ttf_pkg::POS_W-1:0] pos_r [6];
  logic signed [ttf_pkg::TEX_W-1:0] tex_r [4];
  logic [1:0]                       cnt_r, cnt_nxt;
  logic signed [ttf_pkg::POS_W-1:0] cur_pos [3];
  logic                             acc;

  assign cur_pos[0] = in_vtx.pos_x;
  assign cur_pos[1] = in_vtx.pos_y;
  assign cur_pos[2] = in_vtx.pos_z;

  assign in_vtx.ready = !q_full;
  assign acc          = in_vtx.valid && in_vtx.ready;
  assign q_push       = acc && (cnt_r == 2'd2 || in_vtx.end_of_mesh);

  always_comb begin
    q_job = '0;
    q_job.incomplete = (cnt_r != 2'd2);
    for (int i = 0; i < 3; i++) begin
      q_job.e1[i] = ttf_pkg::EDGE_W'(pos_r[3+i]) - ttf_pkg::EDGE_W'(pos_r[i]);
      q_job.e2[i] = ttf_pkg::EDGE_W'(cur_pos[i]) - ttf_pkg::EDGE_W'(pos_r[i]);
    end
    q_job.du1 = ttf_pkg::DELTA_W'(tex_r[2]) - ttf_pkg::DELTA_W'(tex_r[0]);
    q_job.dv1 = ttf_pkg::DELTA_W'(tex_r[3]) - ttf_pkg::DELTA_W'(tex_r[1]);
    q_job.du2 = ttf_pkg::DELTA_W'(in_vtx.tex_u) - ttf_pkg::DELTA_W'(tex_r[0]);
    q_job.dv2 = ttf_pkg::DELTA_W'(in_vtx.tex_v) - ttf_pkg::DELTA_W'(tex_r[1]);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc) begin
      if (cnt_r == 2'd2 || in_vtx.end_of_mesh) begin
        cnt_nxt = 2'd0;
      end else begin
        cnt_nxt = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && cnt_r != 2'd2) begin
      for (int i = 0; i < 3; i++) begin
        if (cnt_r[0]) begin
          pos_r[3+i] <= cur_pos[i];
        end else begin
          pos_r[i] <= cur_pos[i];
        end
      end
      if (cnt_r[0]) begin
        tex_r[2] <= in_vtx.tex_u;
        tex_r[3] <= in_vtx.tex_v;
      end else begin
        tex_r[0] <= in_vtx.tex_u;
        tex_r[1] <= in_vtx.tex_v;
      end
    end
  end

endmodule

// ===== sv/ttf_fifo.sv =====
module ttf_fifo #(
  parameter int DEPTH = ttf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ttf_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output ttf_pkg::job_t dout,
  output logic          empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ttf_pkg::job_t  mem_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

// ===== sv/ttf_div.sv =====
module ttf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ttf_pkg::DIVX_W-1:0]  dividend,
  input  logic [ttf_pkg::DIVD_W-1:0]  divisor,
  output logic                        done,
  output logic [ttf_pkg::QUO_W-1:0]   quot,
  output logic                        ovf
);

  localparam int HI_W = ttf_pkg::DIVX_W - ttf_pkg::QUO_W;
  localparam int DW   = ttf_pkg::DIVD_W;
  localparam int QW   = ttf_pkg::QUO_W;
  localparam int CNTW = $clog2(QW);

  logic              busy_r, done_r, ovf_r;
  logic [CNTW-1:0]   cnt_r;
  logic [DW-1:0]     rem_r, d_r;
  logic [QW-1:0]     low_r, quot_r;
  logic [HI_W-1:0]   hi;
  logic [DW:0]       trial, diff;
  logic              ge;

  assign hi    = dividend[ttf_pkg::DIVX_W-1:QW];
  assign trial = {rem_r, low_r[QW-1]};
  assign ge    = (trial >= {1'b0, d_r});
  assign diff  = trial - {1'b0, d_r};
  assign done  = done_r;
  assign quot  = quot_r;
  assign ovf   = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (hi >= HI_W'(divisor)) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf_r  <= (hi >= HI_W'(divisor));
      rem_r  <= hi[DW-1:0];
      low_r  <= dividend[QW-1:0];
      d_r    <= divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quot_r <= {quot_r[QW-2:0], ge};
      low_r  <= {low_r[QW-2:0], 1'b0};
    end
  end

endmodule

// ===== sv/ttf_back.sv =====
module ttf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ttf_pkg::job_t q_job,
  input  logic          q_empty,
  output logic          q_pop,
  ttf_out_if.source     out_frm
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_TBDIV = 4'd2;
  localparam logic [3:0] ST_NINIT = 4'd3;
  localparam logic [3:0] ST_NSHR  = 4'd4;
  localparam logic [3:0] ST_NSHL  = 4'd5;
  localparam logic [3:0] ST_SQ    = 4'd6;
  localparam logic [3:0] ST_SQRT  = 4'd7;
  localparam logic [3:0] ST_NDIV  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  localparam int NPROD = 20;
  localparam int PW  = ttf_pkg::PAIR_W;
  localparam int CMW = ttf_pkg::CM_W;
  localparam int QW  = ttf_pkg::QUO_W;
  localparam int EW  = ttf_pkg::EDGE_W;
  localparam int MW  = ttf_pkg::MUL_W;

  logic [3:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [2:0]  di_r, di_nxt;
  logic        dbusy_r, out_valid_r;

  ttf_pkg::job_t                      job_r;
  logic signed [ttf_pkg::PROD_W-1:0]  prod_r, acc_r;
  logic signed [PW-1:0]               pair_r [10];
  logic [CMW-1:0]                     cm_r [3];
  logic                               cneg_r [3];
  logic [CMW-1:0]                     top_r, x_r, res_r, bit_r;
  logic signed [QW-1:0]               t_r [3], b_r [3], n_r [3];
  logic [ttf_pkg::STAT_W-1:0]         stat_r;
  logic signed [QW-1:0]               ot_r [3], ob_r [3], on_r [3];
  logic [ttf_pkg::STAT_W-1:0]         ostat_r;

  logic signed [EW-1:0]   e1s [3], e2s [3];
  logic [EW-1:0]          em [6];
  logic [EW-1:0]          eor;
  logic [1:0]             ksh;
  logic signed [QW-1:0]   as [3], bs [3];
  logic signed [ttf_pkg::DELTA_W-1:0] du1s, dv1s, du2s, dv2s;
  logic signed [MW-1:0]   ma, mb;
  logic [3:0]             pi, psel;
  logic                   sec;
  logic [4:0]             pj;
  logic                   det_zero, div_start, div_done, div_ovf, out_load;
  logic [ttf_pkg::DIVX_W-1:0] dx;
  logic [ttf_pkg::DIVD_W-1:0] dd;
  logic [QW-1:0]          div_quot, lim, tm, nm, tb_val, n_val;
  logic signed [PW-1:0]   num_sel;
  logic                   tb_neg;
  logic [PW-1:0]          num_mag;
  logic [CMW-1:0]         cmag [3];
  logic [CMW-1:0]         cmax, rb;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1s[i] = $signed(job_r.e1[i]);
      e2s[i] = $signed(job_r.e2[i]);
      em[i]   = e1s[i][EW-1] ? EW'(-e1s[i]) : EW'(e1s[i]);
      em[i+3] = e2s[i][EW-1] ? EW'(-e2s[i]) : EW'(e2s[i]);
    end
    eor = '0;
    for (int i = 0; i < 6; i++) begin
      eor = eor | em[i];
    end
    ksh = eor[EW-1] ? 2'd2 : (eor[EW-2] ? 2'd1 : 2'd0);
    for (int i = 0; i < 3; i++) begin
      as[i] = e1s[i][EW-1] ? -$signed({1'b0, 31'(em[i] >> ksh)})
                           : $signed({1'b0, 31'(em[i] >> ksh)});
      bs[i] = e2s[i][EW-1] ? -$signed({1'b0, 31'(em[i+3] >> ksh)})
                           : $signed({1'b0, 31'(em[i+3] >> ksh)});
    end
  end

  assign du1s = $signed(job_r.du1);
  assign dv1s = $signed(job_r.dv1);
  assign du2s = $signed(job_r.du2);
  assign dv2s = $signed(job_r.dv2);

  assign pi  = cnt_r[4:1];
  assign sec = cnt_r[0];

  always_comb begin
    ma = '0;
    mb = '0;
    if (state_r == ST_SQ) begin
      if (cnt_r < 5'd3) begin
        ma = $signed({3'b000, cm_r[cnt_r[1:0]][29:0]});
        mb = ma;
      end
    end else begin
      case (pi)
        4'd0: begin
          ma = sec ? MW'(du2s) : MW'(du1s);
          mb = sec ? MW'(dv1s) : MW'(dv2s);
        end
        4'd1, 4'd2, 4'd3: begin
          ma = sec ? MW'(dv1s) : MW'(dv2s);
          mb = sec ? MW'(e2s[2'(pi - 4'd1)]) : MW'(e1s[2'(pi - 4'd1)]);
        end
        4'd4, 4'd5, 4'd6: begin
          ma = sec ? MW'(du2s) : MW'(du1s);
          mb = sec ? MW'(e1s[2'(pi - 4'd4)]) : MW'(e2s[2'(pi - 4'd4)]);
        end
        4'd7: begin
          ma = sec ? MW'(as[2]) : MW'(as[1]);
          mb = sec ? MW'(bs[1]) : MW'(bs[2]);
        end
        4'd8: begin
          ma = sec ? MW'(as[0]) : MW'(as[2]);
          mb = sec ? MW'(bs[2]) : MW'(bs[0]);
        end
        4'd9: begin
          ma = sec ? MW'(as[1]) : MW'(as[0]);
          mb = sec ? MW'(bs[0]) : MW'(bs[1]);
        end
        default: begin
          ma = '0;
          mb = '0;
        end
      endcase
    end
  end

  assign pj       = cnt_r - 5'd1;
  assign det_zero = (pair_r[0] == '0);
  assign psel     = 4'(di_r) + 4'd1;
  assign num_sel  = pair_r[psel];
  assign num_mag  = num_sel[PW-1] ? PW'(-num_sel) : PW'(num_sel);
  assign tb_neg   = num_sel[PW-1] ^ pair_r[0][PW-1];

  always_comb begin
    if (state_r == ST_NDIV) begin
      dx = ttf_pkg::DIVX_W'({cm_r[di_r[1:0]][29:0], 30'd0});
      dd = ttf_pkg::DIVD_W'(res_r[30:0]);
    end else begin
      dx = {num_mag, 16'd0};
      dd = pair_r[0][PW-1] ? ttf_pkg::DIVD_W'(-pair_r[0])
                           : ttf_pkg::DIVD_W'(pair_r[0]);
    end
  end

  assign div_start = ((state_r == ST_TBDIV && !det_zero) || state_r == ST_NDIV) && !dbusy_r;

  ttf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dx),
    .divisor  (dd),
    .done     (div_done),
    .quot     (div_quot),
    .ovf      (div_ovf)
  );

  assign lim    = tb_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign tm     = (div_ovf || div_quot > lim) ? lim : div_quot;
  assign tb_val = tb_neg ? (~tm + 32'd1) : tm;
  assign nm     = (div_quot > ttf_pkg::ONE_Q30) ? ttf_pkg::ONE_Q30 : div_quot;
  assign n_val  = cneg_r[di_r[1:0]] ? (~nm + 32'd1) : nm;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = pair_r[7+i][PW-1] ? CMW'(-pair_r[7+i]) : CMW'(pair_r[7+i]);
    end
    cmax = cmag[0];
    if (cmag[1] > cmax) cmax = cmag[1];
    if (cmag[2] > cmax) cmax = cmag[2];
  end

  assign rb       = res_r + bit_r;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_frm.ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    di_nxt    = di_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_job.incomplete ? ST_OUT : ST_MUL;
          cnt_nxt   = '0;
        end
      end
      ST_MUL: begin
        if (cnt_r == 5'(NPROD)) begin
          state_nxt = ST_TBDIV;
          di_nxt    = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_TBDIV: begin
        if (det_zero) begin
          state_nxt = ST_NINIT;
        end else if (div_done) begin
          if (di_r == 3'd5) begin
            state_nxt = ST_NINIT;
          end else begin
            di_nxt = di_r + 3'd1;
          end
        end
      end
      ST_NINIT: state_nxt = (cmax == '0) ? ST_OUT : ST_NSHR;
      ST_NSHR: begin
        if (top_r[CMW-1:30] == '0) state_nxt = ST_NSHL;
      end
      ST_NSHL: begin
        if (top_r[29]) begin
          state_nxt = ST_SQ;
          cnt_nxt   = '0;
        end
      end
      ST_SQ: begin
        if (cnt_r == 5'd3) begin
          state_nxt = ST_SQRT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_SQRT: begin
        if (bit_r[0]) begin
          state_nxt = ST_NDIV;
          di_nxt    = '0;
        end
      end
      ST_NDIV: begin
        if (div_done) begin
          if (di_r == 3'd2) begin
            state_nxt = ST_OUT;
          end else begin
            di_nxt = di_r + 3'd1;
          end
        end
      end
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      di_r        <= '0;
      dbusy_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      di_r    <= di_nxt;
      if (div_start) begin
        dbusy_r <= 1'b1;
      end else if (div_done) begin
        dbusy_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_frm.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= ttf_pkg::PROD_W'(ma) * ttf_pkg::PROD_W'(mb);
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          job_r <= q_job;
          for (int i = 0; i < 3; i++) begin
            t_r[i] <= '0;
            b_r[i] <= '0;
            n_r[i] <= '0;
          end
          stat_r <= q_job.incomplete ? ttf_pkg::STAT_INCOMPLETE : ttf_pkg::STAT_OK;
        end
      end
      ST_MUL: begin
        if (cnt_r != '0) begin
          if (!pj[0]) begin
            acc_r <= prod_r;
          end else begin
            pair_r[pj[4:1]] <= PW'(acc_r - prod_r);
          end
        end
      end
      ST_TBDIV: begin
        if (det_zero) begin
          stat_r[0] <= 1'b1;
        end else if (div_done) begin
          if (di_r < 3'd3) begin
            t_r[di_r[1:0]] <= tb_val;
          end else begin
            b_r[2'(di_r - 3'd3)] <= tb_val;
          end
        end
      end
      ST_NINIT: begin
        for (int i = 0; i < 3; i++) begin
          cm_r[i]   <= cmag[i];
          cneg_r[i] <= pair_r[7+i][PW-1];
        end
        top_r <= cmax;
        if (cmax == '0) stat_r[1] <= 1'b1;
      end
      ST_NSHR: begin
        if (top_r[CMW-1:30] != '0) begin
          top_r <= top_r >> 1;
          for (int i = 0; i < 3; i++) cm_r[i] <= cm_r[i] >> 1;
        end
      end
      ST_NSHL: begin
        if (!top_r[29]) begin
          top_r <= top_r << 1;
          for (int i = 0; i < 3; i++) cm_r[i] <= cm_r[i] << 1;
        end
      end
      ST_SQ: begin
        if (cnt_r == 5'd1) begin
          x_r <= prod_r[CMW-1:0];
        end else if (cnt_r != '0) begin
          x_r <= x_r + prod_r[CMW-1:0];
        end
        res_r <= '0;
        bit_r <= CMW'(1) << 62;
      end
      ST_SQRT: begin
        if (x_r >= rb) begin
          x_r   <= x_r - rb;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ST_NDIV: begin
        if (div_done) n_r[di_r[1:0]] <= n_val;
      end
      ST_OUT: begin
        if (out_load) begin
          for (int i = 0; i < 3; i++) begin
            ot_r[i] <= t_r[i];
            ob_r[i] <= b_r[i];
            on_r[i] <= n_r[i];
          end
          ostat_r <= stat_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_frm.valid        = out_valid_r;
  assign out_frm.tangent_x    = ot_r[0];
  assign out_frm.tangent_y    = ot_r[1];
  assign out_frm.tangent_z    = ot_r[2];
  assign out_frm.bitangent_x  = ob_r[0];
  assign out_frm.bitangent_y  = ob_r[1];
  assign out_frm.bitangent_z  = ob_r[2];
  assign out_frm.normal_x     = on_r[0];
  assign out_frm.normal_y     = on_r[1];
  assign out_frm.normal_z     = on_r[2];
  assign out_frm.frame_status = ostat_r;

endmodule

// ===== sv/triangle_tangent_frame.sv =====
// Per-triangle tangent frame. Vertices enter on in_vtx, one beat per vertex, in
// triangle order; every third vertex produces one beat on out_frm carrying the
// tangent, bitangent, unit face normal and a status code. A vertex flagged
// end_of_mesh before its triangle is complete drops the partial triangle and
// produces one beat with the incomplete status and all vectors zero.
// The front end takes one vertex per cycle while its job queue has room
// (QUEUE_DEPTH triangles). The back end works on one triangle at a time: the
// products on one shared multiplier, six quotients on one shared divider (a
// quotient that overflows is cut short and saturates), normalizing shifts,
// squares, a square root and three more quotients, so the serial divider and
// square root set its time. The divisions are skipped when the determinant is
// zero and the normal steps when the area is zero.
// The output beat sits in a register, so the back end fills it and moves on,
// waiting for ready only with the next beat to load, while the front end keeps
// taking vertices until the queue is full, at which point in_vtx.ready drops.
// Reset empties the queue, forgets held corners and clears the output valid.
module triangle_tangent_frame #(
  parameter int QUEUE_DEPTH = ttf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ttf_in_if.sink     in_vtx,
  ttf_out_if.source  out_frm
);

  ttf_pkg::job_t push_job, head_job;
  logic          q_push, q_full, q_pop, q_empty;

  ttf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vtx (in_vtx),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  ttf_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (head_job),
    .empty (q_empty)
  );

  ttf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_job   (head_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_frm (out_frm)
  );

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from an empty queue");

  a_incomplete_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_frm.valid && out_frm.frame_status == ttf_pkg::STAT_INCOMPLETE) |->
    (out_frm.tangent_x == 0 && out_frm.bitangent_y == 0 && out_frm.normal_z == 0))
    else $error("incomplete triangle beat carries nonzero vectors");

  a_normal_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_frm.valid |->
    (out_frm.normal_x <= 32'sd1073741824 && out_frm.normal_x >= -32'sd1073741824 &&
     out_frm.normal_y <= 32'sd1073741824 && out_frm.normal_y >= -32'sd1073741824))
    else $error("normal component exceeds unit magnitude");

endmodule
